[rtl/wad_pkg.sv]
`timescale 1ns / 1ps

package wad_pkg;

    localparam int LVL_W    = 16;
    localparam int TIMER_W  = 25;
    localparam int TIME_W   = 24;
    localparam int STEP_W   = 24;
    localparam int NUM_W    = 41;
    localparam int QUO_W    = 16;
    localparam int SAMPLE_W = 16;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_PRESS   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    localparam logic [LVL_W-1:0] FULL_LEVEL = 16'hFFFF;

    typedef enum logic [1:0] {
        STG_ATTACK,
        STG_DECAY,
        STG_SUSTAIN,
        STG_RELEASE
    } wad_stage_t;

    typedef struct packed {
        logic tick_start;
        logic phase_add;
        logic phase_sub;
        logic env_step;
        logic env_div_start;
        logic env_take;
        logic mix_mul;
        logic mix_scale;
        logic mix_take;
        logic out_load;
    } wad_cmd_t;

    typedef struct packed {
        logic phase_ge;
        logic env_div_need;
        logic div_done;
        logic out_full;
    } wad_sts_t;

    // One-period sine entry from its 16.16 position in quarter periods
    function automatic logic signed [SAMPLE_W-1:0] wad_sine(input longint f);
        longint q, x, x2, inner, mid, s, mag;
        q = (f >> 16) & 3;
        x = f & 65535;
        if (q[0])
            x = 65536 - x;
        x2    = (x * x) >> 16;
        inner = 42334 - ((x2 * 5223) >> 16);
        mid   = 102944 - ((x2 * inner) >> 16);
        s     = (x * mid) >> 16;
        if (s > 65536)
            s = 65536;
        mag = (s * 32767 + 32768) >> 16;
        if (mag > 32767)
            mag = 32767;
        if (q >= 2)
            return SAMPLE_W'(-mag);
        return SAMPLE_W'(mag);
    endfunction

endpackage

[rtl/wad_div.sv]
`timescale 1ns / 1ps

module wad_div
    import wad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [TIME_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] den_reg;
    logic [QUO_W-1:0]  lo_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [TIME_W:0]   rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg, lo_reg[QUO_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // quotient above 16 bits saturates at once
                if (num[NUM_W-1:QUO_W] >= {1'b0, den})
                    done_reg <= 1'b1;
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 5'd16;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= num[NUM_W-2:QUO_W];
            lo_reg  <= num[QUO_W-1:0];
            quo_reg <= FULL_LEVEL;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? TIME_W'(rem_sh - {1'b0, den_reg}) : rem_sh[TIME_W-1:0];
            lo_reg  <= {lo_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[rtl/wad_dp.sv]
`timescale 1ns / 1ps

module wad_dp
    import wad_pkg::*;
#(
    parameter int VOICES     = 4,
    parameter int TABLE_SIZE = 256,
    parameter int VW         = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [TIME_W-1:0]   cfg_data,
    input  logic                in_fire,
    input  logic [1:0]          command,
    input  logic [1:0]          voice,
    input  logic [STEP_W-1:0]   phase_step,
    input  wad_cmd_t            cmd,
    input  logic [VW-1:0]       vidx,
    output wad_sts_t            sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int ACC_W = IDX_W + 16;
    localparam int SUM_W = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 1;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(TABLE_SIZE) << 16;

    // floor(n / VOICES) as (n * ceil(2^21 / VOICES)) >> 21, exact for 16-bit n
    localparam int MIX_SH = 21;
    localparam int RCP_W  = MIX_SH + 1;
    localparam int MP_W   = QUO_W + RCP_W;
    localparam logic [RCP_W-1:0] MIX_RECIP =
        RCP_W'(((longint'(1) << MIX_SH) + VOICES - 1) / VOICES);

    logic [TIME_W-1:0] attack_reg, decay_reg, release_reg;
    logic [LVL_W-1:0]  sustain_reg;

    logic [ACC_W-1:0]   phase_reg [VOICES];
    logic [STEP_W-1:0]  step_reg  [VOICES];
    wad_stage_t         stage_reg [VOICES];
    logic [TIMER_W-1:0] timer_reg [VOICES];

    logic signed [SAMPLE_W-1:0] rom_w [TABLE_SIZE];

    for (genvar i = 0; i < TABLE_SIZE; i++)
    begin : g_rom
        localparam longint F = (longint'(i) << 18) / TABLE_SIZE;
        assign rom_w[i] = wad_sine(F);
    end

    logic [SUM_W-1:0]           p_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [TIME_W-1:0]          den_reg;
    logic [LVL_W-1:0]           lvl_reg;
    logic                       dec_mode_reg;
    logic signed [SAMPLE_W-1:0] rom_q_reg;
    logic signed [32:0]         prod_reg;
    logic                       neg_reg;
    logic [QUO_W-1:0]           mq_reg;
    logic [SAMPLE_W-1:0]        mix_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       out_valid_reg;

    logic                voice_ok;
    logic [VW-1:0]       psel;
    logic [TIMER_W-1:0]  t, t_inc, t_next;
    wad_stage_t          st, st_next;
    logic [LVL_W-1:0]    mul_a, lvl_dir;
    logic [TIMER_W-1:0]  mul_b;
    logic [TIME_W-1:0]   den_n;
    logic                need, dec_mode;
    logic [IDX_W-1:0]    idx;
    logic [32:0]         prod_abs;
    logic [MP_W-1:0]     mix_prod;
    logic                div_done;
    logic [QUO_W-1:0]    quo;

    assign voice_ok = int'(voice) < VOICES;
    assign psel     = VW'(voice);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            sustain_reg <= FULL_LEVEL;
            release_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ATTACK:  attack_reg  <= cfg_data;
                REG_DECAY:   decay_reg   <= cfg_data;
                REG_SUSTAIN: sustain_reg <= cfg_data[LVL_W-1:0];
                REG_RELEASE: release_reg <= cfg_data;
            endcase
        end
    end

    assign t     = timer_reg[vidx];
    assign st    = stage_reg[vidx];
    assign t_inc = t + 1'b1;

    always_comb
    begin
        mul_a    = FULL_LEVEL;
        mul_b    = t;
        den_n    = attack_reg;
        need     = 1'b0;
        lvl_dir  = FULL_LEVEL;
        dec_mode = 1'b0;
        t_next   = t;
        st_next  = st;
        unique case (st)
            STG_ATTACK:
            begin
                need = attack_reg != '0;
                if (t_inc > {1'b0, attack_reg})
                begin
                    t_next  = '0;
                    st_next = STG_DECAY;
                end
                else
                    t_next = t_inc;
            end
            STG_DECAY:
            begin
                mul_a    = FULL_LEVEL - sustain_reg;
                den_n    = decay_reg;
                need     = decay_reg != '0;
                lvl_dir  = sustain_reg;
                dec_mode = 1'b1;
                if (t_inc > {1'b0, decay_reg})
                begin
                    t_next  = '0;
                    st_next = STG_SUSTAIN;
                end
                else
                    t_next = t_inc;
            end
            STG_SUSTAIN:
                lvl_dir = sustain_reg;
            STG_RELEASE:
            begin
                mul_a = sustain_reg;
                mul_b = TIMER_W'(release_reg - t[TIME_W-1:0]);
                den_n = release_reg;
                if (t < {1'b0, release_reg})
                begin
                    need   = 1'b1;
                    t_next = t_inc;
                end
                else
                    lvl_dir = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                phase_reg[v] <= '0;
                step_reg[v]  <= '0;
                stage_reg[v] <= STG_RELEASE;
                timer_reg[v] <= '1;
            end
        end
        else if (in_fire && voice_ok && (command == CMD_PRESS || command == CMD_RELEASE))
        begin
            timer_reg[psel] <= '0;
            if (command == CMD_PRESS)
            begin
                step_reg[psel]  <= phase_step;
                stage_reg[psel] <= STG_ATTACK;
            end
            else
                stage_reg[psel] <= STG_RELEASE;
        end
        else if (cmd.phase_sub && !sts.phase_ge)
            phase_reg[vidx] <= p_reg[ACC_W-1:0];
        else if (cmd.env_step)
        begin
            timer_reg[vidx] <= t_next;
            stage_reg[vidx] <= st_next;
        end
    end

    assign idx      = phase_reg[vidx][ACC_W-1:16];
    assign prod_abs = prod_reg[32] ? -prod_reg : prod_reg;
    assign mix_prod = MP_W'(prod_abs[31:16]) * MP_W'(MIX_RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.phase_add)
            p_reg <= SUM_W'(phase_reg[vidx]) + SUM_W'(step_reg[vidx]);
        else if (cmd.phase_sub && sts.phase_ge)
            p_reg <= p_reg - LIMIT;

        if (cmd.env_step)
        begin
            num_reg      <= NUM_W'(mul_a) * NUM_W'(mul_b);
            den_reg      <= den_n;
            lvl_reg      <= lvl_dir;
            dec_mode_reg <= dec_mode;
            rom_q_reg    <= rom_w[idx];
        end
        else if (cmd.env_take)
            lvl_reg <= dec_mode_reg ? FULL_LEVEL - quo : quo;

        if (cmd.mix_mul)
            prod_reg <= rom_q_reg * $signed({1'b0, lvl_reg});
        if (cmd.mix_scale)
        begin
            neg_reg <= prod_reg[32];
            mq_reg  <= mix_prod[MIX_SH +: QUO_W];
        end

        if (cmd.tick_start)
            mix_reg <= '0;
        else if (cmd.mix_take)
            mix_reg <= neg_reg ? mix_reg - mq_reg : mix_reg + mq_reg;

        if (cmd.out_load)
            out_data_reg <= mix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // envelope level is num/den (full level minus num/den in decay), one bit per cycle
    wad_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.env_div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign sts.phase_ge     = p_reg >= LIMIT;
    assign sts.env_div_need = need;
    assign sts.div_done     = div_done;
    assign sts.out_full     = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/wad_ctrl.sv]
`timescale 1ns / 1ps

module wad_ctrl
    import wad_pkg::*;
#(
    parameter int VOICES = 4,
    parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic [1:0]    command,
    input  wad_sts_t      sts,
    output logic          s_tready,
    output wad_cmd_t      cmd,
    output logic [VW-1:0] vidx
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PADD,
        ST_PSUB,
        ST_ENV,
        ST_EDIV,
        ST_EWAIT,
        ST_MMUL,
        ST_MSCALE,
        ST_MACC,
        ST_OUT
    } state_t;

    state_t        state_reg;
    logic [VW-1:0] vcnt_reg;
    logic          tick_fire;
    logic          last;

    assign s_tready  = state_reg == ST_IDLE;
    assign tick_fire = s_tvalid && s_tready && command == CMD_TICK;
    assign last      = int'(vcnt_reg) == VOICES - 1;
    assign vidx      = vcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vcnt_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (tick_fire)
                    begin
                        vcnt_reg  <= '0;
                        state_reg <= ST_PADD;
                    end
                ST_PADD:  state_reg <= ST_PSUB;
                ST_PSUB:
                    if (!sts.phase_ge)
                        state_reg <= ST_ENV;
                ST_ENV:   state_reg <= sts.env_div_need ? ST_EDIV : ST_MMUL;
                ST_EDIV:  state_reg <= ST_EWAIT;
                ST_EWAIT:
                    if (sts.div_done)
                        state_reg <= ST_MMUL;
                ST_MMUL:   state_reg <= ST_MSCALE;
                ST_MSCALE: state_reg <= ST_MACC;
                ST_MACC:
                    if (last)
                        state_reg <= ST_OUT;
                    else
                    begin
                        vcnt_reg  <= vcnt_reg + 1'b1;
                        state_reg <= ST_PADD;
                    end
                ST_OUT:
                    if (!sts.out_full)
                        state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd               = '0;
        cmd.tick_start    = tick_fire;
        cmd.phase_add     = state_reg == ST_PADD;
        cmd.phase_sub     = state_reg == ST_PSUB;
        cmd.env_step      = state_reg == ST_ENV;
        cmd.env_div_start = state_reg == ST_EDIV;
        cmd.env_take      = state_reg == ST_EWAIT && sts.div_done;
        cmd.mix_mul       = state_reg == ST_MMUL;
        cmd.mix_scale     = state_reg == ST_MSCALE;
        cmd.mix_take      = state_reg == ST_MACC;
        cmd.out_load      = state_reg == ST_OUT && !sts.out_full;
    end

endmodule

[rtl/wavetable_adsr_synth_core.sv]
`timescale 1ns / 1ps
// Polyphonic wavetable synth with a linear ADSR envelope per voice.
// Input stream: s_tuser carries the command (tick, press, release),
// s_tdata the voice and the 8.16 phase step. Press and release take
// effect in the transfer cycle and produce nothing. A tick produces one
// signed 16-bit sample on the output stream.
// Configuration: cfg_we / cfg_addr / cfg_data write the attack, decay,
// sustain and release registers; write only while the block is idle.
// Timing: a tick walks the voices one after another. Each voice steps
// through phase add, phase subtract (repeated for each extra phase wrap),
// envelope step, an envelope divide when needed (saturating at once or a
// full 16-step divide), mix multiply, mix scale and accumulate; the mix
// scaling by the voice count is a reciprocal multiply. After the last
// voice the sample is loaded into the output register. s_tready is
// high only between ticks.
// The output register holds one sample; a new tick can be accepted while
// it waits, and the next sample waits in the controller until it is taken.
// Reset clears configuration to defaults, silences all voices and empties
// the output register.
module wavetable_adsr_synth_core
    import wad_pkg::*;
#(
    parameter int VOICES     = 4,
    parameter int TABLE_SIZE = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // voice[1:0], phase_step[25:2], zero pad
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // sample[15:0]
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    wad_cmd_t      cmd;
    wad_sts_t      sts;
    logic [VW-1:0] vidx;
    logic          in_fire;

    assign in_fire = s_tvalid && s_tready;

    wad_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .command  (s_tuser),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd),
        .vidx     (vidx)
    );

    wad_dp #(
        .VOICES     (VOICES),
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .command    (s_tuser),
        .voice      (s_tdata[1:0]),
        .phase_step (s_tdata[25:2]),
        .cmd        (cmd),
        .vidx       (vidx),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

[rtl/wad_chk.sv]
`timescale 1ns / 1ps

module wad_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled sample holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output sample changed while stalled");

    // a tick starts the voice walk, so input closes
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == 2'd0 |=> !s_tready)
        else $error("input still open after tick transfer");

    // press, release and unused commands finish in their own cycle
    a_note_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != 2'd0 |=> s_tready)
        else $error("input closed after non-tick transfer");

    // a new sample only appears at the end of a tick
    a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("sample appeared while idle");

endmodule

bind wavetable_adsr_synth_core wad_chk u_chk (.*);
